### hdl/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types, widths and helpers of the 4x4 fixed-point matrix multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

	localparam int DIM       = 4;
	localparam int ELEM_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int ROW_W     = 2;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_MUL  = 1'b1
	} kind_t;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [ROW_W-1:0]         row_idx_t;

	typedef struct packed {
		kind_t    kind;
		row_idx_t row_index;
		elem_t    value_0;
		elem_t    value_1;
		elem_t    value_2;
		elem_t    value_3;
	} in_word_t;

	typedef struct packed {
		row_idx_t out_row;
		elem_t    result_0;
		elem_t    result_1;
		elem_t    result_2;
		elem_t    result_3;
	} out_word_t;

	// Arithmetic shift right by the fraction width, then clamp to the element range.
	function automatic elem_t scale_sat(input sum_t acc);
		sum_t                  sh;
		logic [SUM_W-ELEM_W:0] hi;
		elem_t                 res;
		sh = acc >>> FRAC_W;
		hi = sh[SUM_W-1:ELEM_W-1];
		if (hi == '0 || hi == '1) begin
			res = sh[ELEM_W-1:0];
		end else if (sh[SUM_W-1]) begin
			res = {1'b1, {(ELEM_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(ELEM_W-1){1'b1}}};
		end
		return res;
	endfunction

endpackage

`default_nettype wire

### hdl/mm4_matrix.sv
// ----------------------------------------------------------------------------
// mm4_matrix
// Right-hand matrix storage, written one row at a time, cleared by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_matrix
	import mm4_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     wr_en,
	input  wire row_idx_t wr_row,
	input  wire elem_t    wr_data [DIM],
	output elem_t         mat     [DIM][DIM]
);

	elem_t mat_q [DIM][DIM];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < DIM; r++) begin
				for (int c = 0; c < DIM; c++) begin
					mat_q[r][c] <= '0;
				end
			end
		end else if (wr_en) begin
			for (int r = 0; r < DIM; r++) begin
				if (wr_row == ROW_W'(r)) begin
					for (int c = 0; c < DIM; c++) begin
						mat_q[r][c] <= wr_data[c];
					end
				end
			end
		end
	end

	assign mat = mat_q;

endmodule

`default_nettype wire

### hdl/mm4_product.sv
// ----------------------------------------------------------------------------
// mm4_product
// First pipeline stage: all element products of the left row with the matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_product
	import mm4_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     en,
	input  wire row_idx_t row_in,
	input  wire elem_t    left    [DIM],
	input  wire elem_t    mat     [DIM][DIM],
	output row_idx_t      row_s1,
	output prod_t         prod_s1 [DIM][DIM]
);

	// prod_s1[c][k] is left[k] times mat[k][c].
	always_ff @(posedge clk) begin
		if (en) begin
			row_s1 <= row_in;
			for (int c = 0; c < DIM; c++) begin
				for (int k = 0; k < DIM; k++) begin
					prod_s1[c][k] <= PROD_W'(left[k]) * PROD_W'(mat[k][c]);
				end
			end
		end
	end

endmodule

`default_nettype wire

### hdl/mm4_reduce.sv
// ----------------------------------------------------------------------------
// mm4_reduce
// Adder tree over the products, then scaling and saturation into the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_reduce
	import mm4_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     en2,
	input  wire logic     en3,
	input  wire logic     en4,
	input  wire row_idx_t row_s1,
	input  wire prod_t    prod_s1 [DIM][DIM],
	output out_word_t     word_s4
);

	localparam int HALF = DIM / 2;

	row_idx_t row_s2;
	row_idx_t row_s3;
	pair_t    pair_s2 [DIM][HALF];
	sum_t     sum_s3  [DIM];

	always_ff @(posedge clk) begin
		if (en2) begin
			row_s2 <= row_s1;
			for (int c = 0; c < DIM; c++) begin
				for (int h = 0; h < HALF; h++) begin
					pair_s2[c][h] <= PAIR_W'(prod_s1[c][2*h]) + PAIR_W'(prod_s1[c][2*h+1]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			row_s3 <= row_s2;
			for (int c = 0; c < DIM; c++) begin
				sum_s3[c] <= SUM_W'(pair_s2[c][0]) + SUM_W'(pair_s2[c][1]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			word_s4.out_row  <= row_s3;
			word_s4.result_0 <= scale_sat(sum_s3[0]);
			word_s4.result_1 <= scale_sat(sum_s3[1]);
			word_s4.result_2 <= scale_sat(sum_s3[2]);
			word_s4.result_3 <= scale_sat(sum_s3[3]);
		end
	end

endmodule

`default_nettype wire

### hdl/matrix_multiply_4x4_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_top
// Streaming 4x4 signed Q16.16 matrix multiplier with a stored right matrix.
// ----------------------------------------------------------------------------
// Each input word is either a load or a multiply. A load writes one row of the
// stored right-hand matrix at the clock edge where it is accepted and produces
// no output word; the matrix is all zeros after reset. A multiply carries one
// row of the left-hand matrix and produces one output word holding the product
// row: each element is the exact sum of four 32x32 products, shifted right by
// 16 bits (rounding toward minus infinity) and clamped to the signed 32-bit
// range. The row number is echoed and selects nothing. Words of either kind
// are accepted one per clock cycle while item_ready is high, so a stream of
// rows runs at full rate unless the output stalls. A multiply passes through
// the four register stages: the product stage, two adder-tree stages, and
// the scaling and saturation stage, whose register drives the output.
// Because the products are formed at acceptance, a load takes effect for the
// very next multiply and never disturbs multiplies already in flight. When
// the output is stalled, the stages fill up and ready drops only once every
// stage holds a word, so no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_4x4_top
	import mm4_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire in_word_t  item,
	output logic           result_valid,
	input  wire logic      result_ready,
	output out_word_t      result
);

	// Valid bits that travel with the words through the four stages.
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;
	logic accept;

	elem_t    left [DIM];
	elem_t    mat  [DIM][DIM];
	row_idx_t row_s1;
	prod_t    prod_s1 [DIM][DIM];

	// A stage may take a new word when it is empty or its word moves on.
	assign en4 = !v_s4 || result_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign item_ready = en1;
	assign accept     = item_valid && item_ready;

	assign left[0] = item.value_0;
	assign left[1] = item.value_1;
	assign left[2] = item.value_2;
	assign left[3] = item.value_3;

	mm4_matrix u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && item.kind == KIND_LOAD),
		.wr_row  (item.row_index),
		.wr_data (left),
		.mat     (mat)
	);

	mm4_product u_product (
		.clk     (clk),
		.en      (en1),
		.row_in  (item.row_index),
		.left    (left),
		.mat     (mat),
		.row_s1  (row_s1),
		.prod_s1 (prod_s1)
	);

	mm4_reduce u_reduce (
		.clk     (clk),
		.en2     (en2),
		.en3     (en3),
		.en4     (en4),
		.row_s1  (row_s1),
		.prod_s1 (prod_s1),
		.word_s4 (result)
	);

	// Only multiply words enter the pipeline as valid; loads are done at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= accept && item.kind == KIND_MUL;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign result_valid = v_s4;

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming 4x4 Q16.16 matrix multiplier.
// ----------------------------------------------------------------------------
// A queue of input words, filled once at time zero, feeds a clocked driver.
// Each accepted word updates a private copy of the stored right matrix or,
// for a multiply, predicts the product row. A clocked monitor takes the
// output words and compares every field against the oldest prediction.
// Directed words hit the arithmetic corners first; random traffic follows
// with random gaps and stalls on both sides. One long output stall forces
// the pipeline to fill up and stall its input.
// ----------------------------------------------------------------------------

module testbench;
	import mm4_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 925;
	localparam int BURST_AT     = 400;	// random word index where the stall burst starts
	localparam int BURST_LEN    = 30;
	localparam int LONG_HOLD    = 150;	// cycles the output side holds off once
	localparam int DRAIN_LIMIT  = 5000;
	localparam int TAIL_CYCLES  = 20;

	// Bounds of the signed element range, held at accumulator width.
	localparam logic signed [SUM_W-1:0] ACC_ELEM_MAX = 66'sh0_7fff_ffff;
	localparam logic signed [SUM_W-1:0] ACC_ELEM_MIN = -66'sh0_8000_0000;

	localparam elem_t E_MAX = 32'sh7fff_ffff;
	localparam elem_t E_MIN = 32'sh8000_0000;
	localparam elem_t E_ONE = 32'sh0001_0000;	// 1.0 in Q16.16

	typedef struct {
		in_word_t word;
		int       gap;          // idle cycles before the word is offered
		bit       drain_first;  // hold the word back until no product row is due
	} pending_word_t;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      item_valid = 1'b0;
	logic      item_ready;
	in_word_t  item = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_word_t result;

	pending_word_t pending_words[$];
	out_word_t     expected_rows[$];

	// The predictor's copy of the stored right matrix; all zeros at the start, as the DUT's is after reset.
	elem_t right_rows[DIM][DIM] = '{default: '0};

	int mismatches      = 0;
	int loads_seen      = 0;
	int muls_seen       = 0;
	int saturated_elems = 0;
	int rows_received   = 0;
	int muls_queued     = 0;
	int hold_at         = -1;
	bit long_hold_done  = 1'b0;
	int stall_left      = 0;

	matrix_multiply_4x4_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One line per mismatch, and a running count for the verdict.
	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Applies one accepted input word to the predicted state. A load overwrites
	// a row of the right matrix; a multiply forms four exact dot products,
	// shifts them right by the fraction width (floor) and clamps each one.
	task automatic apply_word(input in_word_t w);
		elem_t                   left_row[DIM];
		logic signed [SUM_W-1:0] acc;
		logic signed [SUM_W-1:0] lhs;
		logic signed [SUM_W-1:0] rhs;
		elem_t                   col[DIM];
		out_word_t               prod_row;
		left_row = '{w.value_0, w.value_1, w.value_2, w.value_3};
		if (w.kind == KIND_LOAD) begin
			for (int c = 0; c < DIM; c++) begin
				right_rows[w.row_index][c] = left_row[c];
			end
			loads_seen++;
		end else begin
			for (int c = 0; c < DIM; c++) begin
				acc = '0;
				for (int k = 0; k < DIM; k++) begin
					lhs = left_row[k];
					rhs = right_rows[k][c];
					acc = acc + lhs * rhs;
				end
				acc = acc >>> FRAC_W;
				if (acc > ACC_ELEM_MAX) begin
					col[c] = E_MAX;
					saturated_elems++;
				end else if (acc < ACC_ELEM_MIN) begin
					col[c] = E_MIN;
					saturated_elems++;
				end else begin
					col[c] = acc[ELEM_W-1:0];
				end
			end
			prod_row.out_row  = w.row_index;
			prod_row.result_0 = col[0];
			prod_row.result_1 = col[1];
			prod_row.result_2 = col[2];
			prod_row.result_3 = col[3];
			expected_rows.push_back(prod_row);
			muls_seen++;
		end
	endtask

	// Compares one output word, field by field, with the oldest prediction.
	task automatic check_product_row(input out_word_t got);
		out_word_t want;
		elem_t     got_col[DIM];
		elem_t     want_col[DIM];
		if (expected_rows.size() == 0) begin
			report_mismatch($sformatf("product row %0d with no multiply pending", got.out_row));
		end else begin
			want = expected_rows.pop_front();
			got_col  = '{got.result_0, got.result_1, got.result_2, got.result_3};
			want_col = '{want.result_0, want.result_1, want.result_2, want.result_3};
			if (got.out_row !== want.out_row) begin
				report_mismatch($sformatf("out_row got %0d expected %0d",
					got.out_row, want.out_row));
			end
			for (int c = 0; c < DIM; c++) begin
				if (got_col[c] !== want_col[c]) begin
					report_mismatch($sformatf("row %0d result_%0d got %h expected %h",
						want.out_row, c, got_col[c], want_col[c]));
				end
			end
		end
	endtask

	// Element values lean toward the corners: the two extremes, small
	// magnitudes that keep products meaningful, and unrestricted patterns.
	function automatic elem_t draw_element();
		elem_t v;
		case ($urandom_range(0, 7))
			0: v = E_MAX;
			1: v = E_MIN;
			2, 3: v = elem_t'($urandom_range(0, 262143)) - elem_t'(131072);
			4: v = elem_t'($urandom_range(0, 2)) - elem_t'(1);
			default: v = elem_t'($urandom);
		endcase
		return v;
	endfunction

	// Input gaps come in stretches: every third block of fifty words is sent
	// back to back, the rest with a random gap in front of each word.
	function automatic int draw_gap(input int idx);
		return ((idx / 50) % 3 == 1) ? 0 : $urandom_range(0, 10);
	endfunction

	// Output stalls follow a similar pattern, keyed on the rows taken so far: every third block of eighty rows has none.
	function automatic int draw_stall();
		return ((rows_received / 80) % 3 == 2) ? 0 : $urandom_range(0, 10);
	endfunction

	task automatic queue_word(input kind_t k, input row_idx_t r, input elem_t v0,
			input elem_t v1, input elem_t v2, input elem_t v3, input int gap,
			input bit drain_first);
		pending_word_t pw;
		pw.word.kind      = k;
		pw.word.row_index = r;
		pw.word.value_0   = v0;
		pw.word.value_1   = v1;
		pw.word.value_2   = v2;
		pw.word.value_3   = v3;
		pw.gap            = gap;
		pw.drain_first    = drain_first;
		pending_words.push_back(pw);
		if (k == KIND_MUL) begin
			muls_queued++;
		end
	endtask

	// Driver. A word that is offered stays on the bus unchanged until it is
	// taken. Only then is the next word considered: it first waits out any
	// drain request, then its own gap, and is then offered. item_valid gets
	// exactly one nonblocking assignment per edge, so a back-to-back word
	// never sees valid dropped and raised within the same step.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			logic          offer_next;
			pending_word_t nxt;
			offer_next = item_valid;
			if (item_valid && item_ready) begin
				apply_word(item);
				offer_next = 1'b0;
			end
			if (!offer_next && pending_words.size() > 0) begin
				if (pending_words[0].drain_first) begin
					if (expected_rows.size() == 0) begin
						pending_words[0].drain_first = 1'b0;
					end
				end else if (pending_words[0].gap > 0) begin
					pending_words[0].gap--;
				end else begin
					nxt = pending_words.pop_front();
					item <= nxt.word;
					offer_next = 1'b1;
				end
			end
			item_valid <= offer_next;
		end
	end

	// Monitor. After each taken word the output side draws how long it waits
	// before it is ready again. Once, when the rows due before the stall burst
	// have all come in, it holds off for a long stretch instead, while the
	// driver keeps offering multiplies with no gap; the pipeline must fill up
	// and drop item_ready without losing or repeating a word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left = 0;
		end else begin
			logic ready_next;
			ready_next = result_ready;
			if (result_valid && result_ready) begin
				check_product_row(result);
				rows_received++;
				stall_left = draw_stall();
				if (!long_hold_done && rows_received == hold_at) begin
					stall_left = LONG_HOLD;
					long_hold_done = 1'b1;
				end
				ready_next = (stall_left == 0);
			end else if (!result_ready) begin
				if (stall_left > 0) begin
					stall_left--;
				end
				ready_next = (stall_left == 0);
			end
			result_ready <= ready_next;
		end
	end

	// Stimulus, end of run and verdict.
	initial begin
		int n;
		kind_t k;

		// Product against the cleared matrix must be all zeros.
		queue_word(KIND_MUL, 2'd0, E_MAX, E_MIN, -32'sd1, 32'sd1, 0, 1'b0);
		// Identity matrix: every multiply returns its own row, extremes included.
		for (int r = 0; r < DIM; r++) begin
			queue_word(KIND_LOAD, row_idx_t'(r), (r == 0) ? E_ONE : '0, (r == 1) ? E_ONE : '0,
				(r == 2) ? E_ONE : '0, (r == 3) ? E_ONE : '0, $urandom_range(0, 3), 1'b0);
		end
		queue_word(KIND_MUL, 2'd1, E_MAX, E_MIN, -32'sd1, '0, 0, 1'b0);
		queue_word(KIND_MUL, 2'd2, E_ONE, -E_ONE, 32'sd1, -32'sd1, 1, 1'b0);
		// All-maximum matrix: positive and negative overflow clamp.
		for (int r = 0; r < DIM; r++) begin
			queue_word(KIND_LOAD, row_idx_t'(r), E_MAX, E_MAX, E_MAX, E_MAX, 0, 1'b0);
		end
		queue_word(KIND_MUL, 2'd3, E_MAX, E_MAX, E_MAX, E_MAX, 0, 1'b0);
		queue_word(KIND_MUL, 2'd0, E_MIN, E_MIN, E_MIN, E_MIN, 2, 1'b0);
		// All-minimum matrix: the largest possible sum, and a modest one.
		for (int r = 0; r < DIM; r++) begin
			queue_word(KIND_LOAD, row_idx_t'(r), E_MIN, E_MIN, E_MIN, E_MIN, 0, 1'b0);
		end
		queue_word(KIND_MUL, 2'd1, E_MIN, E_MIN, E_MIN, E_MIN, 0, 1'b0);
		queue_word(KIND_MUL, 2'd2, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 0, 1'b0);
		// Tiny negative sum: the shift must round toward minus infinity.
		queue_word(KIND_LOAD, 2'd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 0, 1'b0);
		queue_word(KIND_MUL, 2'd3, -32'sd1, '0, '0, '0, 0, 1'b0);
		queue_word(KIND_MUL, 2'd0, 32'sd1, '0, '0, '0, 3, 1'b0);

		// Random traffic. The first random word waits until the directed part
		// has fully drained, which is also the sender's pause at an empty pipe.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == BURST_AT) begin
				hold_at = muls_queued;
			end
			if (i >= BURST_AT && i < BURST_AT + BURST_LEN) begin
				queue_word(KIND_MUL, row_idx_t'($urandom_range(0, 3)), draw_element(),
					draw_element(), draw_element(), draw_element(), 0, i == BURST_AT);
			end else begin
				k = ($urandom_range(0, 9) < 3) ? KIND_LOAD : KIND_MUL;
				queue_word(k, row_idx_t'($urandom_range(0, 3)), draw_element(),
					draw_element(), draw_element(), draw_element(), draw_gap(i), i == 0);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || item_valid) begin
			@(posedge clk);
		end
		n = 0;
		while (expected_rows.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rows.size() != 0) begin
			report_mismatch($sformatf("%0d product rows never arrived", expected_rows.size()));
		end

		$display("Run covered %0d row loads and %0d multiplies; %0d product rows checked.",
			loads_seen, muls_seen, rows_received);
		$display("%0d product elements clamped; one long output stall filled the pipeline.",
			saturated_elems);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("Timeout: run did not finish");
		$display("Simulation FAILED");
		$finish;
	end

endmodule
